// ===== design/spk_pkg.sv =====
// Shared types and constants for the cubic spline SPH kernel unit.
// No dependencies; the kernel unit uses it by scoped names.
`default_nettype none

package spk_pkg;

  typedef struct packed {
    logic [31:0] distance;
    logic [31:0] smoothing_length;
  } in_t;

  typedef struct packed {
    logic        [47:0] kernel_value;
    logic signed [47:0] kernel_dh;
    logic               bad_length;
    logic               saturated;
  } out_t;

  // 8/pi in Q2.30, rounded.
  localparam logic [31:0] K_EIGHT_OVER_PI = 32'd2734261102;
  localparam logic [32:0] ONE_Q32         = 33'h1_0000_0000;
  localparam int unsigned QUOT_W          = 48;
  localparam int unsigned W_SHIFT         = 10;
  localparam int unsigned DH_SHIFT        = 26;
  localparam logic [47:0] W_MAX           = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] DH_POS_MAX      = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] DH_NEG_MAX      = 48'h8000_0000_0000;

endpackage

`default_nettype wire

// ===== design/spk_rdiv.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; used by the kernel unit for the ratio and the final scaling.
`default_nettype none

module spk_rdiv #(
  parameter int unsigned DW = 32,
  parameter int unsigned NQ = 32,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NQ-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NQ-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  // The starting remainder holds the dividend bits above the quotient and
  // must be below the divisor; the low bits are shifted in one per stage.
  logic [NQ:0]   v_q;
  logic [DW-1:0] r_q [NQ+1];
  logic [NQ-1:0] x_q [NQ+1];
  logic [NQ-1:0] qt_q[NQ+1];
  logic [DW-1:0] d_q [NQ+1];
  logic [SW-1:0] s_q [NQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NQ-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]  <= rem_i;
      x_q[0]  <= num_i;
      qt_q[0] <= '0;
      d_q[0]  <= den_i;
      s_q[0]  <= side_i;
    end
  end

  for (genvar k = 1; k <= NQ; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {r_q[k-1], x_q[k-1][NQ-1]};
    assign diff  = trial - {1'b0, d_q[k-1]};
    assign ge    = trial >= {1'b0, d_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        x_q[k]  <= x_q[k-1] << 1;
        qt_q[k] <= {qt_q[k-1][NQ-2:0], ge};
        d_q[k]  <= d_q[k-1];
        s_q[k]  <= s_q[k-1];
      end
    end
  end

  assign valid_o = v_q[NQ];
  assign quot_o  = qt_q[NQ];
  assign side_o  = s_q[NQ];

endmodule

`default_nettype wire

// ===== design/sph_cubic_spline_kernel_unit.sv =====
// 3-D cubic spline SPH kernel unit: kernel value and its smoothing-length derivative.
// Depends on spk_pkg and on the pipelined divider spk_rdiv.
//
// Usage: each request carries a pair distance R and a smoothing length h,
// both unsigned Q16.16. The result carries W (unsigned Q24.24), dW/dh
// (signed Q24.24), a flag for a zero smoothing length and a flag that is
// set when either result was clipped to its range.
// Both channels use valid and stall; a request moves at a clock edge with
// valid high and stall low.
// Pipeline: the q = R/h divider (33 stages), five arithmetic stages, the
// two final dividers (49 stages each) and the output register. Throughput
// is one request per cycle while out_stall_i does not hold the pipeline;
// the 48 bit-stages of the final dividers make up most of the depth.
// The whole pipeline advances together. While a result sits in the output
// register with out_stall_i high, every stage holds and in_stall_o is high;
// nothing is lost or repeated. Reset clears all valid bits at once.
`default_nettype none

module sph_cubic_spline_kernel_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spk_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output spk_pkg::out_t out_data_o
);

  // Global advance: the pipeline moves unless a finished result is held.
  logic adv;
  logic out_valid_q;
  spk_pkg::out_t out_data_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // Flags decided at entry: zero length, distance at or beyond support, inner branch.
  logic [31:0] in_r, in_h;
  logic        in_bad, in_zero, in_inner;
  logic [34:0] qd_side_in, qd_side_out;
  logic        qd_valid;
  logic [31:0] qd_quot;

  assign in_r     = in_data_i.distance;
  assign in_h     = in_data_i.smoothing_length;
  assign in_bad   = (in_h == '0);
  assign in_zero  = (in_r >= in_h);
  assign in_inner = ({in_r, 1'b0} <= {1'b0, in_h});
  assign qd_side_in = {in_h, in_bad, in_zero, in_inner};

  // q = floor(R * 2^32 / h); R < h keeps the quotient within 32 bits.
  spk_rdiv #(.DW(32), .NQ(32), .SW(35)) u_qdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .rem_i   (in_r),
    .num_i   ('0),
    .den_i   (in_h),
    .side_i  (qd_side_in),
    .valid_o (qd_valid),
    .quot_o  (qd_quot),
    .side_o  (qd_side_out)
  );

  // Stage 1: base u (q inner, 1-q outer), u^2, v = 2q-1, h^2.
  logic [31:0] s1_h, s1_u, s1_q;
  logic [2:0]  s1_flags;
  logic [32:0] s1_t;
  logic [63:0] s1_uu;
  logic        m1_v_q;
  logic [31:0] m1_u_q, m1_u2_q, m1_vv_q, m1_h_q;
  logic [63:0] m1_hh_q;
  logic [2:0]  m1_flags_q;

  assign s1_h     = qd_side_out[34:3];
  assign s1_flags = qd_side_out[2:0];
  assign s1_q     = qd_quot;
  assign s1_t     = spk_pkg::ONE_Q32 - {1'b0, s1_q};
  assign s1_u     = s1_flags[0] ? s1_q : s1_t[31:0];
  assign s1_uu    = s1_u * s1_u;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_u_q     <= s1_u;
      m1_u2_q    <= s1_uu[63:32];
      m1_vv_q    <= {s1_q[30:0], 1'b0};
      m1_hh_q    <= s1_h * s1_h;
      m1_h_q     <= s1_h;
      m1_flags_q <= s1_flags;
    end
  end

  // Stage 2: u^3, u^2*v, partial products of h^3.
  logic [63:0] s2_u3, s2_ut;
  logic        m2_v_q;
  logic [31:0] m2_u2_q, m2_u3_q, m2_ut_q, m2_h_q;
  logic [63:0] m2_p3lo_q, m2_p3hi_q;
  logic [2:0]  m2_flags_q;

  assign s2_u3 = m1_u2_q * m1_u_q;
  assign s2_ut = m1_u2_q * m1_vv_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_u2_q    <= m1_u2_q;
      m2_u3_q    <= s2_u3[63:32];
      m2_ut_q    <= s2_ut[63:32];
      m2_p3lo_q  <= m1_hh_q[31:0] * m1_h_q;
      m2_p3hi_q  <= m1_hh_q[63:32] * m1_h_q;
      m2_h_q     <= m1_h_q;
      m2_flags_q <= m1_flags_q;
    end
  end

  // Stage 3: polynomials f and g of the selected branch, h^3 sum.
  logic [39:0] s3_fi, s3_gi, s3_gneg_v;
  logic [32:0] s3_f;
  logic [34:0] s3_g;
  logic        s3_gneg;
  logic        m3_v_q;
  logic [32:0] m3_f_q;
  logic [34:0] m3_g_q;
  logic        m3_gneg_q;
  logic [95:0] m3_h3_q;
  logic [31:0] m3_h_q;
  logic [2:0]  m3_flags_q;

  assign s3_fi = 40'(spk_pkg::ONE_Q32) - 40'(m2_u2_q) * 40'd6 + 40'(m2_u3_q) * 40'd6;
  assign s3_gi = 40'(spk_pkg::ONE_Q32) * 40'd3 - 40'(m2_u2_q) * 40'd30
               + 40'(m2_u3_q) * 40'd36;
  assign s3_gneg_v = 40'd0 - s3_gi;

  always_comb begin
    if (m2_flags_q[0]) begin
      s3_f    = s3_fi[39] ? '0 : s3_fi[32:0];
      s3_gneg = !s3_gi[39] && (s3_gi != '0);
      s3_g    = s3_gi[39] ? s3_gneg_v[34:0] : s3_gi[34:0];
    end else begin
      s3_f    = {m2_u3_q, 1'b0};
      s3_gneg = 1'b0;
      s3_g    = 35'(m2_ut_q) * 35'd6;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m3_f_q     <= s3_f;
      m3_g_q     <= s3_g;
      m3_gneg_q  <= s3_gneg;
      m3_h3_q    <= {32'd0, m2_p3lo_q} + {m2_p3hi_q, 32'd0};
      m3_h_q     <= m2_h_q;
      m3_flags_q <= m2_flags_q;
    end
  end

  // Stage 4: K*F, K*G, partial products of h^4.
  logic [64:0] s4_kf;
  logic [66:0] s4_kg;
  logic [34:0] s4_kg_top;
  logic        m4_v_q;
  logic [64:0] m4_kf_q;
  logic [66:0] m4_kg_q;
  logic        m4_gneg_q;
  logic [95:0] m4_h3_q;
  logic [63:0] m4_p0_q, m4_p1_q, m4_p2_q;
  logic [1:0]  m4_flags_q;

  assign s4_kf = 65'(64'(spk_pkg::K_EIGHT_OVER_PI) * 64'(m3_f_q[31:0]))
               + (m3_f_q[32] ? {1'b0, spk_pkg::K_EIGHT_OVER_PI, 32'd0} : 65'd0);
  assign s4_kg_top = spk_pkg::K_EIGHT_OVER_PI * m3_g_q[34:32];
  assign s4_kg = 67'(64'(spk_pkg::K_EIGHT_OVER_PI) * 64'(m3_g_q[31:0]))
               + {s4_kg_top, 32'd0};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m4_kf_q    <= s4_kf;
      m4_kg_q    <= s4_kg;
      m4_gneg_q  <= m3_gneg_q;
      m4_h3_q    <= m3_h3_q;
      m4_p0_q    <= m3_h3_q[31:0] * m3_h_q;
      m4_p1_q    <= m3_h3_q[63:32] * m3_h_q;
      m4_p2_q    <= m3_h3_q[95:64] * m3_h_q;
      m4_flags_q <= m3_flags_q[2:1];
    end
  end

  // Stage 5: scaled dividends and h^4.
  logic        m5_v_q;
  logic [74:0] m5_xw_q;
  logic [92:0] m5_xd_q;
  logic [95:0] m5_h3_q;
  logic [127:0] m5_h4_q;
  logic        m5_gneg_q;
  logic [1:0]  m5_flags_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m5_xw_q    <= {m4_kf_q, 10'd0};
      m5_xd_q    <= {m4_kg_q, 26'd0};
      m5_h3_q    <= m4_h3_q;
      m5_h4_q    <= {64'd0, m4_p0_q} + {32'd0, m4_p1_q, 32'd0} + {m4_p2_q, 64'd0};
      m5_gneg_q  <= m4_gneg_q;
      m5_flags_q <= m4_flags_q;
    end
  end

  // Valid bits of the arithmetic stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
      m4_v_q <= 1'b0;
      m5_v_q <= 1'b0;
    end else if (adv) begin
      m1_v_q <= qd_valid;
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
      m4_v_q <= m3_v_q;
      m5_v_q <= m4_v_q;
    end
  end

  // A quotient of 2^48 or more shows as the high dividend bits reaching the
  // divisor; that case saturates and the divider output is ignored.
  logic ovw, ovd;
  logic [2:0] w_side_in, w_side_out;
  logic [1:0] d_side_in, d_side_out;
  logic       w_valid, d_valid;
  logic [47:0] w_quot, d_quot;

  assign ovw = 96'(m5_xw_q[74:48]) >= m5_h3_q;
  assign ovd = 128'(m5_xd_q[92:48]) >= m5_h4_q;
  assign w_side_in = {ovw, m5_flags_q};
  assign d_side_in = {ovd, m5_gneg_q};

  spk_rdiv #(.DW(96), .NQ(spk_pkg::QUOT_W), .SW(3)) u_wdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (m5_v_q),
    .rem_i   (96'(m5_xw_q[74:48])),
    .num_i   (m5_xw_q[47:0]),
    .den_i   (m5_h3_q),
    .side_i  (w_side_in),
    .valid_o (w_valid),
    .quot_o  (w_quot),
    .side_o  (w_side_out)
  );

  spk_rdiv #(.DW(128), .NQ(spk_pkg::QUOT_W), .SW(2)) u_ddiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (m5_v_q),
    .rem_i   (128'(m5_xd_q[92:48])),
    .num_i   (m5_xd_q[47:0]),
    .den_i   (m5_h4_q),
    .side_i  (d_side_in),
    .valid_o (d_valid),
    .quot_o  (d_quot),
    .side_o  (d_side_out)
  );

  // Output stage: saturation, sign and the special cases.
  logic        f_ovw, f_ovd, f_gneg, f_bad, f_zero, f_over;
  logic [47:0] f_lim, f_mag, f_dh;
  spk_pkg::out_t f_res;

  assign f_ovw  = w_side_out[2];
  assign f_bad  = w_side_out[1];
  assign f_zero = w_side_out[0];
  assign f_ovd  = d_side_out[1];
  assign f_gneg = d_side_out[0];
  assign f_lim  = f_gneg ? spk_pkg::DH_NEG_MAX : spk_pkg::DH_POS_MAX;
  assign f_over = f_ovd || (d_quot > f_lim);
  assign f_mag  = f_over ? f_lim : d_quot;
  assign f_dh   = f_gneg ? (48'd0 - f_mag) : f_mag;

  always_comb begin
    f_res = '0;
    if (f_bad) begin
      f_res.bad_length = 1'b1;
    end else if (!f_zero) begin
      f_res.kernel_value = f_ovw ? spk_pkg::W_MAX : w_quot;
      f_res.kernel_dh    = $signed(f_dh);
      f_res.saturated    = f_ovw || f_over;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= w_valid && d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= f_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  // The two final dividers run in lockstep.
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_valid == d_valid)
    else $error("final dividers out of step");

  // A zero smoothing length gives zero results and no clipping.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.bad_length |->
      out_data_q.kernel_value == '0 && out_data_q.kernel_dh == '0 &&
      !out_data_q.saturated)
    else $error("bad length with nonzero result");

  // A clipped result sits at one of the range limits.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.saturated |->
      out_data_q.kernel_value == spk_pkg::W_MAX ||
      out_data_q.kernel_dh == $signed(spk_pkg::DH_POS_MAX) ||
      out_data_q.kernel_dh == $signed(spk_pkg::DH_NEG_MAX))
    else $error("saturated result not at a limit");

  // Input is held off only while a finished result waits, and the held
  // result stays in place.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(out_data_q) && out_valid_q)
    else $error("held result changed");
`endif

endmodule

`default_nettype wire

// ===== test/tb_sph_cubic_spline_kernel_unit.sv =====
// Self-checking testbench for the 3-D cubic spline SPH kernel unit.
// Depends on spk_pkg and sph_cubic_spline_kernel_unit; predicts each result
// with wide integer arithmetic and checks it against the design's output stream.
`timescale 1ns / 100ps
`default_nettype none

module tb_sph_cubic_spline_kernel_unit;

  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES   = 120;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  spk_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  spk_pkg::out_t out_data_o;

  // Expected results, oldest first.
  spk_pkg::out_t kernel_results_q[$];
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  bit            idle_en;

  sph_cubic_spline_kernel_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // floor(K * v * 2^s / d^n), clipped to lim. Repeated floor division by d
  // equals a single floor division by d^n, which keeps the numbers in 128 bits.
  function automatic logic [47:0] scale_by_length(input logic [63:0] v, input int s,
                                                  input logic [63:0] d, input int n,
                                                  input logic [47:0] lim,
                                                  inout bit clip);
    logic [127:0] x;
    x = 128'(v) * 128'(spk_pkg::K_EIGHT_OVER_PI);
    x = x << s;
    for (int i = 0; i < n; i++) begin
      x = x / 128'(d);
    end
    if (x > 128'(lim)) begin
      clip = 1'b1;
      return lim;
    end
    return x[47:0];
  endfunction

  // Kernel value and smoothing-length derivative for one pair.
  function automatic spk_pkg::out_t kernel_of_pair(input spk_pkg::in_t d);
    spk_pkg::out_t res;
    logic [63:0]   r, h, q, q2, q3, t, t2, t3, v, fval, gmag;
    longint        f, g;
    bit            gneg, clip;
    logic [47:0]   dh;
    res  = '0;
    r    = 64'(d.distance);
    h    = 64'(d.smoothing_length);
    fval = '0;
    gmag = '0;
    gneg = 1'b0;
    clip = 1'b0;
    if (h == 0) begin
      res.bad_length = 1'b1;
      return res;
    end
    // At or beyond the support radius the kernel vanishes.
    if (r >= h) begin
      return res;
    end
    q = (r << 32) / h;
    if (2 * r <= h) begin
      q2 = (q * q) >> 32;
      q3 = (q2 * q) >> 32;
      f  = longint'(64'h1_0000_0000) - 6 * longint'(q2) + 6 * longint'(q3);
      g  = 3 * longint'(64'h1_0000_0000) - 30 * longint'(q2) + 36 * longint'(q3);
      fval = (f > 0) ? 64'(f) : 64'd0;
      if (g >= 0) begin
        gmag = 64'(g);
        gneg = (g != 0);
      end else begin
        gmag = 64'(-g);
      end
    end else begin
      t    = 64'h1_0000_0000 - q;
      t2   = (t * t) >> 32;
      t3   = (t2 * t) >> 32;
      v    = 2 * q - 64'h1_0000_0000;
      fval = 2 * t3;
      gmag = 6 * ((t2 * v) >> 32);
    end
    res.kernel_value = scale_by_length(fval, spk_pkg::W_SHIFT, h, 3, spk_pkg::W_MAX, clip);
    dh = scale_by_length(gmag, spk_pkg::DH_SHIFT, h, 4,
                         gneg ? spk_pkg::DH_NEG_MAX : spk_pkg::DH_POS_MAX, clip);
    res.kernel_dh = gneg ? -dh : dh;
    res.saturated = clip;
    return res;
  endfunction

  // Sends one request, with an optional random gap in front of it, and
  // records its expected result once the design has taken it.
  task automatic send_pair(input logic [31:0] r, input logic [31:0] h);
    spk_pkg::in_t d;
    d.distance         = r;
    d.smoothing_length = h;
    if (idle_en && ($urandom_range(0, 3) == 0)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    kernel_results_q.push_back(kernel_of_pair(d));
  endtask

  // Random pair: the smoothing length spans many magnitudes; most distances
  // are a random fraction of it so both branches are exercised.
  task automatic send_random_pair();
    logic [31:0] h, r;
    logic [63:0] frac;
    h = $urandom >> $urandom_range(0, 31);
    if ($urandom_range(0, 7) == 0) begin
      h = $urandom;
    end
    if ($urandom_range(0, 9) == 0) begin
      r = $urandom;
    end else begin
      frac = 64'($urandom);
      r    = 32'((64'(h) * frac) >> 32);
    end
    send_pair(r, h);
  endtask

  task automatic wait_all_results();
    while (kernel_results_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Corner cases: zero length, distance at and past the support, the branch
  // boundary at 2R = h, zero distance, tiny lengths that clip, and extremes.
  task automatic test_corner_cases();
    send_pair(32'd0, 32'd0);
    send_pair(32'hFFFF_FFFF, 32'd0);
    send_pair(32'd100, 32'd100);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'h0001_0000);
    send_pair(32'd0, 32'h0001_0000);
    send_pair(32'd0, 32'hFFFF_FFFF);
    send_pair(32'd0, 32'd1);
    send_pair(32'd0, 32'd2);
    send_pair(32'h0000_8000, 32'h0001_0000);
    send_pair(32'h0000_8001, 32'h0001_0000);
    send_pair(32'h0000_7FFF, 32'h0001_0000);
    send_pair(32'h0000_FFFF, 32'h0001_0000);
    send_pair(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h8000_0000, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_pair(32'd1, 32'd3);
    send_pair(32'd2, 32'd3);
    send_pair(32'h0000_4000, 32'h0001_0000);
    send_pair(32'h0000_C000, 32'h0001_0000);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA);
    send_pair(32'h0100_0000, 32'h0400_0000);
  endtask

  task automatic test_random_pairs(input int unsigned count);
    repeat (count) send_random_pair();
  endtask

  // The sender holds off until the pipeline is empty, then restarts.
  task automatic test_drain_and_restart();
    in_valid_i <= 1'b0;
    wait_all_results();
    repeat (5) @(posedge clk_i);
    repeat (50) send_random_pair();
  endtask

  // Back-to-back traffic with both sides ready once any stall burst in progress ends.
  task automatic test_full_rate();
    idle_en = 1'b0;
    repeat (300) send_random_pair();
  endtask

  // Result checker and the receiver's random stall bursts.
  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    spk_pkg::out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (kernel_results_q.size() == 0) begin
          $error("result with no request outstanding: %p", out_data_o);
          mismatch_count++;
        end else begin
          want = kernel_results_q.pop_front();
          if (out_data_o.kernel_value !== want.kernel_value) begin
            $error("kernel_value expected %0d actual %0d", want.kernel_value,
                   out_data_o.kernel_value);
            mismatch_count++;
          end
          if (out_data_o.kernel_dh !== want.kernel_dh) begin
            $error("kernel_dh expected %0d actual %0d", want.kernel_dh,
                   out_data_o.kernel_dh);
            mismatch_count++;
          end
          if (out_data_o.bad_length !== want.bad_length) begin
            $error("bad_length expected %0b actual %0b", want.bad_length,
                   out_data_o.bad_length);
            mismatch_count++;
          end
          if (out_data_o.saturated !== want.saturated) begin
            $error("saturated expected %0b actual %0b", want.saturated,
                   out_data_o.saturated);
            mismatch_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= (stall_left != 0);
      end else if (idle_en && ($urandom_range(0, 7) == 0)) begin
        stall_left = $urandom_range(1, 8);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    idle_en        = 1'b1;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_cases();
    test_random_pairs(600);
    test_drain_and_restart();
    test_random_pairs(550);
    test_full_rate();
    in_valid_i <= 1'b0;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
